/* rtl/core/tssd_pkg.sv */
// ----------------------------------------------------------------------------
// tssd_pkg: shared types and helpers for the scratchpad decoder
// Holds the scratchpad layout, fault codes, decode constants and the CRC step.
// ----------------------------------------------------------------------------
package tssd_pkg;

  // scratchpad geometry
  localparam int unsigned PosW = 4;
  localparam logic [PosW-1:0] PosTempLow  = 4'd0;
  localparam logic [PosW-1:0] PosTempHigh = 4'd1;
  localparam logic [PosW-1:0] PosRemain   = 4'd6;
  localparam logic [PosW-1:0] PosPerDeg   = 4'd7;
  localparam logic [PosW-1:0] PosCrc      = 4'd8;
  localparam logic [PosW-1:0] PosDone     = 4'd9;

  // decode constants
  localparam logic [7:0]         FamilyExtended = 8'h10;
  localparam logic [7:0]         CpdFull        = 8'h10;
  localparam logic [7:0]         CrcPoly        = 8'h8C;
  localparam logic signed [15:0] RawPowerOn     = 16'sh0550;
  localparam logic signed [15:0] RawMin         = -16'sd880;
  localparam logic signed [15:0] RawMax         = 16'sd2000;
  localparam logic [15:0]        FracMask       = 16'hFFF0;
  localparam logic [15:0]        RemainBias     = 16'd12;
  localparam logic signed [19:0] FahrOffset     = 20'sd2560;
  localparam logic signed [4:0]  FahrScale      = 5'sd9;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_CRC      = 2'd1,
    FAULT_RANGE    = 2'd2,
    FAULT_POWER_ON = 2'd3
  } fault_e;

  // bytes kept from one scratchpad frame
  typedef struct packed {
    logic [7:0] temp_low;
    logic [7:0] temp_high;
    logic [7:0] count_remain;
    logic [7:0] count_per_degree;
  } scratch_t;

  typedef struct packed {
    logic               reading_ok;
    fault_e             fault_code;
    logic signed [15:0] celsius;
    logic signed [15:0] fahrenheit;
  } result_t;

  // reflected crc-8, one byte, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] b;
    logic       mix;
    c = crc;
    b = data;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ b[0];
      c   = c >> 1;
      if (mix) begin
        c = c ^ CrcPoly;
      end
      b = b >> 1;
    end
    return c;
  endfunction

endpackage

/* rtl/core/tssd_decode.sv */
// ----------------------------------------------------------------------------
// tssd_decode: temperature decode of one finished scratchpad frame
// Widens the raw value, checks crc, range and power-on value, builds fahrenheit.
// ----------------------------------------------------------------------------
module tssd_decode (
  input  tssd_pkg::scratch_t scratch_i,
  input  logic [7:0]         crc_i,
  input  logic [7:0]         crc_byte_i,
  input  logic [7:0]         family_code_i,
  output tssd_pkg::result_t  result_o
);
  import tssd_pkg::*;

  logic [15:0]        raw_base;
  logic [15:0]        raw_shift;
  logic [15:0]        raw_bits;
  logic signed [15:0] raw;
  logic signed [19:0] fahr_full;

  always_comb begin
    raw_base  = {scratch_i.temp_high, scratch_i.temp_low};
    raw_shift = raw_base << 3;
    raw_bits  = raw_base;
    if (family_code_i == FamilyExtended) begin
      if (scratch_i.count_per_degree == CpdFull) begin
        // refine with count-remain, wraps in 16 bits
        raw_bits = (raw_shift & FracMask) + RemainBias - {8'd0, scratch_i.count_remain};
      end else begin
        raw_bits = raw_shift;
      end
    end
  end

  assign raw       = $signed(raw_bits);
  assign fahr_full = 20'(raw) * 20'(FahrScale) + FahrOffset;

  always_comb begin
    result_o.reading_ok = 1'b0;
    result_o.fault_code = FAULT_NONE;
    result_o.celsius    = raw;
    result_o.fahrenheit = '0;
    if (crc_i != crc_byte_i) begin
      result_o.fault_code = FAULT_CRC;
    end else if (raw < RawMin || raw > RawMax) begin
      result_o.fault_code = FAULT_RANGE;
    end else if (raw == RawPowerOn) begin
      result_o.fault_code = FAULT_POWER_ON;
    end else begin
      result_o.reading_ok = 1'b1;
      result_o.fahrenheit = fahr_full[15:0];
    end
  end

endmodule

/* rtl/core/temp_sensor_scratchpad_decode_unit.sv */
// ----------------------------------------------------------------------------
// temp_sensor_scratchpad_decode_unit: crc-checked temperature scratchpad decode
// Collects nine scratchpad bytes, one per transfer, and emits one checked
// temperature reading per frame on the crc byte.
// ----------------------------------------------------------------------------
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, data_byte_i, frame_start_i,| slave
//          | family_code_i                                    |
//  out     | out_valid_o/out_ready_i, reading_ok_o,           | master
//          | fault_code_o, celsius_sixteenths_o,              |
//          | fahrenheit_eightieths_o                          |
//
// one byte is taken per cycle while in_ready_o is high; crc step and decode
// are combinational logic ahead of the result register, so a reading
// appears in the cycle after its crc byte is taken
// reset clears the byte position, crc and the result valid flag
// a held result stalls input only while the result register is full and
// not being taken; bytes that give no result still wait in that case
// ----------------------------------------------------------------------------
module temp_sensor_scratchpad_decode_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_start_i,
  input  logic [7:0]         family_code_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               reading_ok_o,
  output logic [1:0]         fault_code_o,
  output logic signed [15:0] celsius_sixteenths_o,
  output logic signed [15:0] fahrenheit_eightieths_o
);
  import tssd_pkg::*;

  // frame state
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      crc_q, crc_d;
  scratch_t        scratch_q, scratch_d;

  // result register
  logic    out_valid_q, out_valid_d;
  result_t result_q, result_d;
  result_t dec_result;

  logic            in_xfer;
  logic [PosW-1:0] pos_eff;
  logic [7:0]      crc_eff;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // frame_start restarts position and crc for this very byte
  assign pos_eff = frame_start_i ? PosTempLow : pos_q;
  assign crc_eff = frame_start_i ? 8'd0 : crc_q;

  tssd_decode u_decode (
    .scratch_i     (scratch_q),
    .crc_i         (crc_eff),
    .crc_byte_i    (data_byte_i),
    .family_code_i (family_code_i),
    .result_o      (dec_result)
  );

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    scratch_d   = scratch_q;
    out_valid_d = out_valid_q && !out_ready_i;
    result_d    = result_q;
    if (in_xfer) begin
      if (pos_eff < PosCrc) begin
        // data bytes: run crc and keep the bytes we need
        crc_d = crc8_update(crc_eff, data_byte_i);
        pos_d = pos_eff + 4'd1;
        case (pos_eff)
          PosTempLow:  scratch_d.temp_low         = data_byte_i;
          PosTempHigh: scratch_d.temp_high        = data_byte_i;
          PosRemain:   scratch_d.count_remain     = data_byte_i;
          PosPerDeg:   scratch_d.count_per_degree = data_byte_i;
          default:     scratch_d = scratch_q;
        endcase
      end else if (pos_eff == PosCrc) begin
        // crc byte closes the frame and loads a reading
        pos_d       = PosDone;
        crc_d       = crc_eff;
        out_valid_d = 1'b1;
        result_d    = dec_result;
      end
      // past the crc byte: ignored until the next frame_start
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosTempLow;
      crc_q       <= 8'd0;
      out_valid_q <= 1'b0;
      scratch_q   <= '0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      scratch_q   <= scratch_d;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o             = out_valid_q;
  assign reading_ok_o            = result_q.reading_ok;
  assign fault_code_o            = result_q.fault_code;
  assign celsius_sixteenths_o    = result_q.celsius;
  assign fahrenheit_eightieths_o = result_q.fahrenheit;

`ifndef SYNTHESIS
  // ok flag and fault code agree
  a_ok_vs_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reading_ok_o == (fault_code_o == FAULT_NONE)))
    else $error("reading_ok disagrees with fault_code");

  // fahrenheit is zero on any rejected reading
  a_fahr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !reading_ok_o) |-> (fahrenheit_eightieths_o == 16'sd0))
    else $error("fahrenheit not zero on a fault");

  // taking the crc byte loads a reading
  a_crc_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !frame_start_i && pos_q == PosCrc) |=> out_valid_q)
    else $error("crc byte gave no reading");

  // byte position never runs past the done mark
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosDone)
    else $error("byte position out of range");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the scratchpad decode unit
// Feeds scratchpad frames byte by byte and keeps a shadow decoder that tracks
// position, crc and kept bytes. Each reading the unit returns is compared
// field by field against the oldest pending prediction. Directed frames cover
// the range limits, the power-on value, fault priority, the extended format
// and framing corner cases. Random traffic follows, mostly well-formed frames
// with random content and some noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import tssd_pkg::*;

  localparam int         ItemsTarget      = 1950;
  localparam int         StallLimit       = 2000;
  localparam int         SettleCycles     = 4;
  localparam int         BackpressureHold = 150;
  // a family code that keeps the plain 12-bit format
  localparam logic [7:0] FamilyPlain      = 8'h28;

  logic               clk_i                   = 1'b0;
  logic               rst_ni                  = 1'b0;
  logic               in_valid_i              = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i             = 8'h00;
  logic               frame_start_i           = 1'b0;
  logic [7:0]         family_code_i           = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i             = 1'b1;
  logic               reading_ok_o;
  logic [1:0]         fault_code_o;
  logic signed [15:0] celsius_sixteenths_o;
  logic signed [15:0] fahrenheit_eightieths_o;

  // shadow decoder state, zero after reset like the unit
  logic [PosW-1:0] sh_pos     = '0;
  logic [7:0]      sh_crc     = '0;
  logic [7:0]      sh_low     = '0;
  logic [7:0]      sh_high    = '0;
  logic [7:0]      sh_remain  = '0;
  logic [7:0]      sh_per_deg = '0;

  // predicted readings, oldest first
  result_t readings_due[$];

  int items_taken  = 0;
  int errors       = 0;
  int idle_count   = 0;
  // idling knobs, percent chance of a gap before a transfer
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  // long receiver hold-off request, consumed by the sink process
  int hold_cycles  = 0;

  always #5 clk_i = ~clk_i;

  temp_sensor_scratchpad_decode_unit DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .data_byte_i            (data_byte_i),
    .frame_start_i          (frame_start_i),
    .family_code_i          (family_code_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .reading_ok_o           (reading_ok_o),
    .fault_code_o           (fault_code_o),
    .celsius_sixteenths_o   (celsius_sixteenths_o),
    .fahrenheit_eightieths_o(fahrenheit_eightieths_o)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 80) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // reflected crc-8, poly x^8+x^5+x^4+1, data lsb first
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    int         i;
    c = crc;
    for (i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = {1'b0, c[7:1]} ^ (fb ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

  // temperatures right at and just past the decision points
  function automatic logic [15:0] corner_temp(input int sel);
    case (sel)
      0:       return 16'(RawMin);
      1:       return 16'(RawMin - 1);
      2:       return 16'(RawMax);
      3:       return 16'(RawMax + 1);
      4:       return 16'(RawPowerOn);
      5:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // shadow decoder: advance on one accepted byte, queue a reading on the crc byte
  task automatic decode_byte(input logic [7:0] data, input logic start, input logic [7:0] fam);
    result_t     r;
    logic [15:0] bits;
    int          raw;
    if (start) begin
      sh_pos = PosTempLow;
      sh_crc = 8'h00;
    end
    // frame already complete: byte is dropped
    if (sh_pos >= PosDone) begin
      return;
    end
    items_taken++;
    if (sh_pos != PosCrc) begin
      sh_crc = crc8_fold(sh_crc, data);
      case (sh_pos)
        PosTempLow:  sh_low     = data;
        PosTempHigh: sh_high    = data;
        PosRemain:   sh_remain  = data;
        PosPerDeg:   sh_per_deg = data;
        default: ;
      endcase
      sh_pos = sh_pos + 1'b1;
      return;
    end
    sh_pos = PosDone;
    bits   = {sh_high, sh_low};
    // 9-bit half-degree format, optionally refined by count remain
    if (fam == FamilyExtended) begin
      bits = bits << 3;
      if (sh_per_deg == CpdFull) begin
        bits = (bits & FracMask) + RemainBias - {8'h00, sh_remain};
      end
    end
    raw          = $signed(bits);
    r.celsius    = bits;
    r.reading_ok = 1'b0;
    r.fahrenheit = '0;
    if (sh_crc != data) begin
      r.fault_code = FAULT_CRC;
    end else if (raw < RawMin || raw > RawMax) begin
      r.fault_code = FAULT_RANGE;
    end else if (raw == RawPowerOn) begin
      r.fault_code = FAULT_POWER_ON;
    end else begin
      r.fault_code = FAULT_NONE;
      r.reading_ok = 1'b1;
      r.fahrenheit = 16'(raw * FahrScale + FahrOffset);
    end
    readings_due.push_back(r);
  endtask

  // offer one byte, possibly after a gap, and hold it until the transfer
  task automatic push_byte(input logic [7:0] data, input logic start, input logic [7:0] fam);
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= data;
    frame_start_i <= start;
    family_code_i <= fam;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(data, start, fam);
  endtask

  // nine bytes with a proper (or deliberately broken) crc byte;
  // family only matters on the crc byte, the others carry noise
  task automatic send_frame(input logic [7:0] fam, input logic [15:0] temp,
                            input logic [7:0] remain, input logic [7:0] per_deg,
                            input bit crc_bad, input bit marked);
    logic [7:0] pad [9];
    logic [7:0] crc;
    int         k;
    pad[0] = temp[7:0];
    pad[1] = temp[15:8];
    for (k = 2; k < 6; k++) begin
      pad[k] = 8'($urandom);
    end
    pad[6] = remain;
    pad[7] = per_deg;
    crc = 8'h00;
    for (k = 0; k < 8; k++) begin
      crc = crc8_fold(crc, pad[k]);
    end
    pad[8] = crc_bad ? crc ^ 8'($urandom_range(1, 255)) : crc;
    for (k = 0; k < 9; k++) begin
      push_byte(pad[k], (k == 0) && marked, (k == 8) ? fam : 8'($urandom));
    end
  endtask

  // leading bytes of a frame that never completes
  task automatic send_partial(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      push_byte(8'($urandom), k == 0, 8'($urandom));
    end
  endtask

  // well-formed frame with random content, biased toward interesting readings
  task automatic random_frame();
    logic [7:0]  fam;
    logic [7:0]  remain;
    logic [7:0]  per_deg;
    logic [15:0] temp;
    int          pick;
    pick    = $urandom_range(0, 99);
    fam     = (pick < 45) ? FamilyExtended : (pick < 55) ? 8'($urandom) : FamilyPlain;
    per_deg = (fam == FamilyExtended && $urandom_range(0, 9) < 7) ? CpdFull : 8'($urandom);
    remain  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
    pick    = $urandom_range(0, 99);
    if (pick < 20) begin
      temp = 16'($urandom);
    end else if (fam == FamilyExtended) begin
      temp = {($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00, 8'($urandom)};
    end else if (pick < 80) begin
      temp = 16'($urandom_range(0, 2880) - 880);
    end else begin
      temp = corner_temp($urandom_range(0, 6));
    end
    send_frame(fam, temp, remain, per_deg, $urandom_range(0, 99) < 12, 1'b1);
  endtask

  // sender pause: wait for every pending reading, then let the pipe settle
  task automatic drain_readings();
    in_valid_i <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // after reset the first byte counts as byte 0 even without frame_start
  task automatic test_unframed_first_frame();
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    send_frame(8'h00, 16'hFFFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    send_frame(8'hFF, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b1);
    drain_readings();
  endtask

  // both range limits, one step past each, and the power-on value
  task automatic test_range_limits();
    int sel;
    for (sel = 0; sel < 5; sel++) begin
      send_frame(FamilyPlain, corner_temp(sel), 8'h00, 8'h10, 1'b0, 1'b1);
    end
    drain_readings();
  endtask

  // crc mismatch must win over range and power-on faults
  task automatic test_crc_priority();
    send_frame(FamilyPlain, 16'(RawPowerOn), 8'h00, 8'h10, 1'b1, 1'b1);
    send_frame(FamilyPlain, 16'h7FFF, 8'h00, 8'h10, 1'b1, 1'b1);
    send_frame(FamilyPlain, 16'h0191, 8'h00, 8'h10, 1'b1, 1'b1);
    drain_readings();
  endtask

  // 9-bit format: plain shift, count-remain refinement, wrap, limits
  task automatic test_extended_format();
    send_frame(FamilyExtended, 16'h00AA, 8'h03, 8'h0C, 1'b0, 1'b1); // power-on after shift
    send_frame(FamilyExtended, 16'h0032, 8'h0C, CpdFull, 1'b0, 1'b1);
    send_frame(FamilyExtended, 16'hFF92, 8'h0C, CpdFull, 1'b0, 1'b1); // exactly low limit
    send_frame(FamilyExtended, 16'hFF92, 8'h0D, CpdFull, 1'b0, 1'b1); // one below
    send_frame(FamilyExtended, 16'h00FA, 8'h00, CpdFull, 1'b0, 1'b1); // over high limit
    send_frame(FamilyExtended, 16'h0000, 8'hFF, CpdFull, 1'b0, 1'b1); // remain wraps
    drain_readings();
  endtask

  // trailing bytes after a frame, restart mid-frame and on the crc slot
  task automatic test_framing_edges();
    send_frame(FamilyPlain, 16'h0191, 8'h00, 8'h10, 1'b0, 1'b1);
    repeat (3) push_byte(8'($urandom), 1'b0, 8'($urandom));
    send_partial(4);
    send_frame(FamilyPlain, 16'h0320, 8'h00, 8'h10, 1'b0, 1'b1);
    send_partial(8);
    send_frame(FamilyExtended, 16'h0032, 8'h05, CpdFull, 1'b0, 1'b1);
    drain_readings();
  endtask

  // receiver holds off while the sender keeps offering, so input stalls
  task automatic test_output_backpressure();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_cycles  = BackpressureHold;
    repeat (6) random_frame();
    drain_readings();
  endtask

  // bulk random traffic, idling profile changes every few dozen rounds
  task automatic test_random_traffic();
    int round;
    int pick;
    round = 0;
    while (items_taken < ItemsTarget) begin
      if (round % 30 == 0) begin
        case ((round / 30) % 5)
          0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
          1: begin tx_gap_pct = 25; rx_stall_pct = 25; end
          2: begin tx_gap_pct = 5;  rx_stall_pct = 60; end
          3: begin tx_gap_pct = 60; rx_stall_pct = 5;  end
          default: begin tx_gap_pct = 40; rx_stall_pct = 40; end
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        random_frame();
      end else if (pick < 85) begin
        random_frame();
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 8'($urandom));
      end else if (pick < 93) begin
        send_partial($urandom_range(1, 8));
      end else begin
        // raw noise with stray frame marks
        repeat ($urandom_range(1, 6)) begin
          push_byte(8'($urandom), $urandom_range(0, 3) == 0, 8'($urandom));
        end
      end
      round++;
    end
  endtask

  // result sink: random stalls plus the occasional long hold-off
  always begin : result_sink
    @(posedge clk_i);
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      repeat (hold_cycles) @(posedge clk_i);
      hold_cycles = 0;
      out_ready_i <= 1'b1;
    end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
      out_ready_i <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
      out_ready_i <= 1'b1;
    end
  end

  // compare each reading transfer against the oldest prediction
  always @(posedge clk_i) begin : reading_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (readings_due.size() == 0) begin
        $error("reading with none pending: ok %0d fault %0d celsius %0d",
               reading_ok_o, fault_code_o, celsius_sixteenths_o);
        errors++;
      end else begin
        want = readings_due.pop_front();
        if (reading_ok_o !== want.reading_ok) begin
          $error("reading_ok: expected %0d, got %0d", want.reading_ok, reading_ok_o);
          errors++;
        end
        if (fault_code_o !== want.fault_code) begin
          $error("fault_code: expected %0d, got %0d", want.fault_code, fault_code_o);
          errors++;
        end
        if (celsius_sixteenths_o !== want.celsius) begin
          $error("celsius_sixteenths: expected %0d, got %0d",
                 want.celsius, celsius_sixteenths_o);
          errors++;
        end
        if (fahrenheit_eightieths_o !== want.fahrenheit) begin
          $error("fahrenheit_eightieths: expected %0d, got %0d",
                 want.fahrenheit, fahrenheit_eightieths_o);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without any transfer on either side ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_count <= 0;
    end else if (idle_count >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    // reset held low from the start, then released once
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_unframed_first_frame();
    test_range_limits();
    test_crc_priority();
    test_extended_format();
    test_framing_edges();
    test_output_backpressure();
    test_random_traffic();
    drain_readings();

    if (readings_due.size() != 0) begin
      $error("%0d readings never arrived", readings_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* temp_sensor_scratchpad_decode_unit.f */
rtl/core/tssd_pkg.sv
rtl/core/tssd_decode.sv
rtl/core/temp_sensor_scratchpad_decode_unit.sv
verif/testbench.sv
